// ===== hw/rtl/slc_pkg.sv =====
package slc_pkg;

   localparam int CNT_W       = 7;
   localparam int COORD_W     = 16;
   localparam int DIST_W      = 35;
   localparam int ROOT_W      = 18;
   localparam int QUEUE_DEPTH = 4;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 40;
   localparam int ID_OUT_W    = 6;
   localparam int MDIST_W     = 17;
   localparam int COUNT_OUT_W = 6;

   localparam logic [DIST_W-1:0] DIST_INF = '1;

   typedef struct packed {
      logic                       store;
      logic [CNT_W-1:0]           index;
      logic signed [COORD_W-1:0]  y;
      logic signed [COORD_W-1:0]  x;
      logic                       run;
      logic [CNT_W-1:0]           total;
      logic                       dropped;
   } cmd_type;

endpackage

// ===== hw/rtl/slc_ram.sv =====
module slc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/slc_front.sv =====
module slc_front #(
   parameter int MAX_POINTS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [slc_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic                                 req_tlast,
   input  logic                                 queue_full,
   output logic                                 cmd_push,
   output slc_pkg::cmd_type                     cmd
);

   logic [slc_pkg::CNT_W-1:0] count_ff;
   logic                      dropped_ff;
   logic                      fits;

   assign req_tready = !queue_full;
   assign cmd_push   = req_tvalid && req_tready;
   assign fits       = count_ff < slc_pkg::CNT_W'(MAX_POINTS);

   always_comb begin
      cmd.store   = fits;
      cmd.index   = count_ff;
      cmd.x       = req_tdata[15:0];
      cmd.y       = req_tdata[31:16];
      cmd.run     = req_tlast;
      cmd.total   = fits ? slc_pkg::CNT_W'(count_ff + 1'b1) : count_ff;
      cmd.dropped = dropped_ff | !fits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else if (cmd_push) begin
         if (req_tlast) begin
            count_ff   <= '0;
            dropped_ff <= 1'b0;
         end else begin
            count_ff   <= cmd.total;
            dropped_ff <= cmd.dropped;
         end
      end
   end

endmodule

// ===== hw/rtl/slc_queue.sv =====
module slc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W:0]   fill_ff;

   assign full  = fill_ff == (PTR_W+1)'(DEPTH);
   assign empty = fill_ff == '0;
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hw/rtl/slc_back.sv =====
module slc_back #(
   parameter int MAX_POINTS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   input  slc_pkg::cmd_type                cmd,
   output logic                            cmd_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [slc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,
   output logic                            rsp_tuser
);

   localparam int ID_W   = $clog2(2 * MAX_POINTS);
   localparam int PT_W   = $clog2(MAX_POINTS);
   localparam int DADR_W = 2 * ID_W;
   localparam int D_W    = slc_pkg::DIST_W;
   localparam int R_W    = slc_pkg::ROOT_W;
   localparam int CW     = slc_pkg::COORD_W;

   typedef enum logic [4:0] {
      S_IDLE, S_BLD_A, S_BLD_AW, S_BLD_B, S_BLD_BW, S_BLD_MUL, S_BLD_WR,
      S_SC_INIT, S_SC_RD, S_SC_CMP, S_SZ_A, S_SZ_AW, S_SZ_B, S_SZ_BW, S_SZ_W,
      S_UP_RA, S_UP_RB, S_UP_WR, S_SQ_INIT, S_SQ, S_EMIT
   } state_type;

   state_type              state_ff;
   logic [ID_W-1:0]        n_ff, k_ff, a_ff, b_ff, i_ff, bx_ff, by_ff;
   logic                   dropped_ff;
   logic [2*MAX_POINTS-1:0] used_ff;
   logic [2*CW-1:0]        pa_ff;
   logic [CW-1:0]          adx_ff, ady_ff;
   logic [2*CW-1:0]        sqx_ff, sqy_ff;
   logic [D_W-1:0]         best_ff, d1_ff;
   logic [5:0]             sa_ff;
   logic [6:0]             cnt_ff;
   logic [2*R_W-1:0]       val_ff;
   logic [R_W+1:0]         rem_ff;
   logic [R_W-1:0]         root_ff;
   logic [4:0]             step_ff;
   logic                   rsp_valid_ff;
   logic [slc_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                   rsp_last_ff, rsp_user_ff;

   logic                   pt_we, pt_re;
   logic [PT_W-1:0]        pt_wa, pt_ra;
   logic [2*CW-1:0]        pt_wd, pt_rd;
   logic                   d_we, d_re;
   logic [DADR_W-1:0]      d_wa, d_ra;
   logic [D_W-1:0]         d_wd, d_rd;
   logic                   sz_we, sz_re;
   logic [PT_W-1:0]        sz_wa, sz_ra;
   logic [5:0]             sz_wd, sz_rd;

   logic [ID_W-1:0]        lim;
   logic                   sc_last_b, sc_done;
   logic [CW:0]            dx, dy;
   logic [R_W+3:0]         sq_shift, sq_trial;
   logic [D_W-1:0]         dmin;
   logic                   load;

   slc_ram #(.WIDTH(2*CW), .DEPTH(MAX_POINTS)) u_points (
      .clock(clock), .wr_en(pt_we), .wr_addr(pt_wa), .wr_data(pt_wd),
      .rd_en(pt_re), .rd_addr(pt_ra), .rd_data(pt_rd));

   slc_ram #(.WIDTH(D_W), .DEPTH(2**DADR_W)) u_dist (
      .clock(clock), .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd),
      .rd_en(d_re), .rd_addr(d_ra), .rd_data(d_rd));

   slc_ram #(.WIDTH(6), .DEPTH(MAX_POINTS)) u_sizes (
      .clock(clock), .wr_en(sz_we), .wr_addr(sz_wa), .wr_data(sz_wd),
      .rd_en(sz_re), .rd_addr(sz_ra), .rd_data(sz_rd));

   assign lim       = ID_W'(n_ff + k_ff);
   assign sc_last_b = b_ff == ID_W'(lim - 1'b1);
   assign sc_done   = sc_last_b && (ID_W'(a_ff + ID_W'(2)) == lim);
   assign dx        = (CW+1)'($signed(pa_ff[CW-1:0])) - (CW+1)'($signed(pt_rd[CW-1:0]));
   assign dy        = (CW+1)'($signed(pa_ff[2*CW-1:CW])) - (CW+1)'($signed(pt_rd[2*CW-1:CW]));
   assign sq_shift  = {rem_ff, val_ff[2*R_W-1:2*R_W-2]};
   assign sq_trial  = (R_W+4)'({root_ff, 2'b01});
   assign dmin      = (d1_ff < d_rd) ? d1_ff : d_rd;
   assign load      = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign cmd_pop   = (state_ff == S_IDLE) && cmd_valid;

   always_comb begin
      pt_we = cmd_pop && cmd.store;
      pt_wa = cmd.index[PT_W-1:0];
      pt_wd = {cmd.y, cmd.x};
      pt_re = (state_ff == S_BLD_A) || (state_ff == S_BLD_B);
      pt_ra = (state_ff == S_BLD_A) ? a_ff[PT_W-1:0] : b_ff[PT_W-1:0];
      d_we  = 1'b0;
      d_wa  = {a_ff, b_ff};
      d_wd  = D_W'(sqx_ff) + D_W'(sqy_ff);
      d_re  = 1'b0;
      d_ra  = {a_ff, b_ff};
      sz_we = 1'b0;
      sz_wa = k_ff[PT_W-1:0];
      sz_wd = cnt_ff[5:0];
      sz_re = 1'b0;
      sz_ra = PT_W'(bx_ff - n_ff);
      case (state_ff)
         S_BLD_WR: begin
            d_we = 1'b1;
         end
         S_SC_RD: begin
            d_re = !used_ff[a_ff] && !used_ff[b_ff];
         end
         S_SZ_A: begin
            sz_re = bx_ff >= n_ff;
         end
         S_SZ_B: begin
            sz_re = by_ff >= n_ff;
            sz_ra = PT_W'(by_ff - n_ff);
         end
         S_SZ_W: begin
            sz_we = 1'b1;
         end
         S_UP_RA: begin
            d_re = (i_ff != lim) && !used_ff[i_ff];
            d_ra = (i_ff < bx_ff) ? {i_ff, bx_ff} : {bx_ff, i_ff};
         end
         S_UP_RB: begin
            d_re = 1'b1;
            d_ra = (i_ff < by_ff) ? {i_ff, by_ff} : {by_ff, i_ff};
         end
         S_UP_WR: begin
            d_we = 1'b1;
            d_wa = {i_ff, lim};
            d_wd = dmin;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid && cmd.run && (cmd.total >= slc_pkg::CNT_W'(2))) begin
                  n_ff       <= ID_W'(cmd.total);
                  dropped_ff <= cmd.dropped;
                  used_ff    <= '0;
                  a_ff       <= '0;
                  b_ff       <= ID_W'(1);
                  state_ff   <= S_BLD_A;
               end
            end
            S_BLD_A: state_ff <= S_BLD_AW;
            S_BLD_AW: begin
               pa_ff    <= pt_rd;
               state_ff <= S_BLD_B;
            end
            S_BLD_B: state_ff <= S_BLD_BW;
            S_BLD_BW: begin
               adx_ff   <= dx[CW] ? CW'(-dx) : dx[CW-1:0];
               ady_ff   <= dy[CW] ? CW'(-dy) : dy[CW-1:0];
               state_ff <= S_BLD_MUL;
            end
            S_BLD_MUL: begin
               sqx_ff   <= adx_ff * adx_ff;
               sqy_ff   <= ady_ff * ady_ff;
               state_ff <= S_BLD_WR;
            end
            S_BLD_WR: begin
               if (b_ff == ID_W'(n_ff - 1'b1)) begin
                  if (ID_W'(a_ff + ID_W'(2)) == n_ff) begin
                     k_ff     <= '0;
                     state_ff <= S_SC_INIT;
                  end else begin
                     a_ff     <= ID_W'(a_ff + 1'b1);
                     b_ff     <= ID_W'(a_ff + ID_W'(2));
                     state_ff <= S_BLD_A;
                  end
               end else begin
                  b_ff     <= ID_W'(b_ff + 1'b1);
                  state_ff <= S_BLD_B;
               end
            end
            S_SC_INIT: begin
               a_ff     <= '0;
               b_ff     <= ID_W'(1);
               best_ff  <= slc_pkg::DIST_INF;
               state_ff <= S_SC_RD;
            end
            S_SC_RD, S_SC_CMP: begin
               if (state_ff == S_SC_RD && !used_ff[a_ff] && !used_ff[b_ff]) begin
                  state_ff <= S_SC_CMP;
               end else begin
                  if (state_ff == S_SC_CMP && d_rd <= best_ff) begin
                     best_ff <= d_rd;
                     bx_ff   <= a_ff;
                     by_ff   <= b_ff;
                  end
                  if (sc_done) begin
                     state_ff <= S_SZ_A;
                  end else if (sc_last_b) begin
                     a_ff     <= ID_W'(a_ff + 1'b1);
                     b_ff     <= ID_W'(a_ff + ID_W'(2));
                     state_ff <= S_SC_RD;
                  end else begin
                     b_ff     <= ID_W'(b_ff + 1'b1);
                     state_ff <= S_SC_RD;
                  end
               end
            end
            S_SZ_A: begin
               sa_ff    <= 6'd1;
               state_ff <= (bx_ff >= n_ff) ? S_SZ_AW : S_SZ_B;
            end
            S_SZ_AW: begin
               sa_ff    <= sz_rd;
               state_ff <= S_SZ_B;
            end
            S_SZ_B: begin
               state_ff <= (by_ff >= n_ff) ? S_SZ_BW : S_SZ_W;
               cnt_ff   <= 7'(sa_ff) + 7'd1;
            end
            S_SZ_BW: begin
               cnt_ff   <= 7'(sa_ff) + 7'(sz_rd);
               state_ff <= S_SZ_W;
            end
            S_SZ_W: begin
               used_ff[bx_ff] <= 1'b1;
               used_ff[by_ff] <= 1'b1;
               i_ff           <= '0;
               state_ff       <= S_UP_RA;
            end
            S_UP_RA: begin
               if (i_ff == lim) begin
                  state_ff <= S_SQ_INIT;
               end else if (used_ff[i_ff]) begin
                  i_ff <= ID_W'(i_ff + 1'b1);
               end else begin
                  state_ff <= S_UP_RB;
               end
            end
            S_UP_RB: begin
               d1_ff    <= d_rd;
               state_ff <= S_UP_WR;
            end
            S_UP_WR: begin
               i_ff     <= ID_W'(i_ff + 1'b1);
               state_ff <= S_UP_RA;
            end
            S_SQ_INIT: begin
               val_ff   <= (2*R_W)'(best_ff);
               rem_ff   <= '0;
               root_ff  <= '0;
               step_ff  <= 5'(R_W);
               state_ff <= S_SQ;
            end
            S_SQ: begin
               val_ff <= {val_ff[2*R_W-3:0], 2'b00};
               if (sq_shift >= sq_trial) begin
                  rem_ff  <= (R_W+2)'(sq_shift - sq_trial);
                  root_ff <= {root_ff[R_W-2:0], 1'b1};
               end else begin
                  rem_ff  <= (R_W+2)'(sq_shift);
                  root_ff <= {root_ff[R_W-2:0], 1'b0};
               end
               step_ff <= step_ff - 1'b1;
               if (step_ff == 5'd1) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (load) begin
                  if (ID_W'(k_ff + ID_W'(2)) == n_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     k_ff     <= ID_W'(k_ff + 1'b1);
                     state_ff <= S_SC_INIT;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= {5'b0, cnt_ff[5:0], root_ff[slc_pkg::MDIST_W-1:0],
                         slc_pkg::ID_OUT_W'(by_ff), slc_pkg::ID_OUT_W'(bx_ff)};
         rsp_last_ff <= ID_W'(k_ff + ID_W'(2)) == n_ff;
         rsp_user_ff <= dropped_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== hw/rtl/single_linkage_clustering.sv =====
// Single-linkage clustering of up to MAX_POINTS 2-D points (Q12.4). Points stream in one item
// per cycle, while the queue is not full, into a four-entry command queue; tlast closes the
// set, and points beyond capacity are dropped and flagged in rsp_tuser. A set of n points then
// yields n-1 merge items, each with the two cluster ids, the floor square root of the squared
// merge distance and the member count; tlast marks the final merge. The pace is set by the
// single read port of the distance memory: it is built one point pair at a time, then each
// round scans the pairs (reading only unused ones), updates each live cluster, reads the sizes
// and runs the 18-step square root. Points of the next set queue meanwhile.
module single_linkage_clustering #(
   parameter int MAX_POINTS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [slc_pkg::REQ_DATA_W-1:0]      req_tdata,   // point_x, point_y
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [slc_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // first_id, second_id, merge_distance, member_count
   output logic                                rsp_tlast,
   output logic                                rsp_tuser    // overflow
);

   localparam int CMD_W = $bits(slc_pkg::cmd_type);

   slc_pkg::cmd_type front_cmd, back_cmd;
   logic             push, pop, full, empty;
   logic [CMD_W-1:0] head;

   slc_front #(.MAX_POINTS(MAX_POINTS)) u_front (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast), .queue_full(full),
      .cmd_push(push), .cmd(front_cmd));

   slc_queue #(.WIDTH(CMD_W), .DEPTH(slc_pkg::QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(front_cmd), .pop(pop),
      .head(head), .full(full), .empty(empty));

   assign back_cmd = slc_pkg::cmd_type'(head);

   slc_back #(.MAX_POINTS(MAX_POINTS)) u_back (
      .clock(clock), .reset(reset), .cmd_valid(!empty), .cmd(back_cmd), .cmd_pop(pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser));

endmodule
